@@ src/box_iou_ratio_top_macros.svh @@
// Assertion macros for the box IoU ratio block.
`ifndef BOX_IOU_RATIO_TOP_MACROS_SVH
`define BOX_IOU_RATIO_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define BIOU_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define BIOU_IMPLY_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/biou_pkg.sv @@
// Shared types and constants for the box IoU ratio block.
package biou_pkg;

	localparam int FIELD_BITS = 16;
	localparam int RATIO_BITS = 17;

	typedef logic signed [FIELD_BITS-1:0] coord_field_t;
	typedef logic [RATIO_BITS-1:0] ratio_t;

	typedef struct packed {
		logic overlap;
		logic bad_union;
	} biou_flags_t;

endpackage

@@ src/biou_ifs.sv @@
// Valid/ready channel interfaces for box pairs and IoU results.
interface biou_pair_if;
	import biou_pkg::*;

	logic         valid;
	logic         ready;
	coord_field_t box_a_left;
	coord_field_t box_a_low_y;
	coord_field_t box_a_right;
	coord_field_t box_a_high_y;
	coord_field_t box_b_left;
	coord_field_t box_b_low_y;
	coord_field_t box_b_right;
	coord_field_t box_b_high_y;

	modport source (
		output valid, box_a_left, box_a_low_y, box_a_right, box_a_high_y,
		output box_b_left, box_b_low_y, box_b_right, box_b_high_y,
		input  ready
	);
	modport sink (
		input  valid, box_a_left, box_a_low_y, box_a_right, box_a_high_y,
		input  box_b_left, box_b_low_y, box_b_right, box_b_high_y,
		output ready
	);
endinterface

interface biou_result_if;
	import biou_pkg::*;

	logic   valid;
	logic   ready;
	ratio_t overlap_ratio;
	logic   boxes_overlap;
	logic   bad_union;

	modport source (
		output valid, overlap_ratio, boxes_overlap, bad_union,
		input  ready
	);
	modport sink (
		input  valid, overlap_ratio, boxes_overlap, bad_union,
		output ready
	);
endinterface

@@ src/biou_front.sv @@
// Front pipeline: box extents, areas, intersection and union.
module biou_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	biou_pair_if.sink                pair,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2*COORD_BITS+1:0]  num,
	output logic [2*COORD_BITS+1:0]  den,
	output biou_pkg::biou_flags_t    flg
);
	import biou_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int AREA_W = 2 * COORD_BITS + 2;
	localparam int UNI_W  = 2 * COORD_BITS + 3;
	localparam int DEN_W  = 2 * COORD_BITS + 2;

	coord_field_t                  raw [8];
	logic signed [COORD_BITS-1:0]  crd [8];

	assign raw[0] = pair.box_a_left;
	assign raw[1] = pair.box_a_low_y;
	assign raw[2] = pair.box_a_right;
	assign raw[3] = pair.box_a_high_y;
	assign raw[4] = pair.box_b_left;
	assign raw[5] = pair.box_b_low_y;
	assign raw[6] = pair.box_b_right;
	assign raw[7] = pair.box_b_high_y;

	// wider coordinates see the field zero-extended
	for (genvar g = 0; g < 8; g++) begin : g_crd
		if (COORD_BITS <= FIELD_BITS) begin : g_cut
			assign crd[g] = raw[g][COORD_BITS-1:0];
		end else begin : g_ext
			assign crd[g] = {{(COORD_BITS-FIELD_BITS){1'b0}}, raw[g]};
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic signed [DIFF_W-1:0]     dxa_s1, dya_s1, dxb_s1, dyb_s1;
	logic signed [COORD_BITS-1:0] lft_s1, rgt_s1, bot_s1, hiy_s1;

	logic signed [AREA_W-1:0]     area_a_s2, area_b_s2;
	logic signed [DIFF_W-1:0]     iw_s2, ih_s2;
	logic                         ovl_s2;

	logic signed [AREA_W-1:0]     area_a_s3, area_b_s3, inter_s3;
	logic                         ovl_s3;

	logic [DEN_W-1:0]             num_s4, den_s4;
	biou_flags_t                  flg_s4;

	logic signed [UNI_W-1:0]      uni_c;

	assign adv_s4 = !vld_s4 || out_ready;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign pair.ready = adv_s1;

	assign uni_c = UNI_W'(area_a_s3) + UNI_W'(area_b_s3) - UNI_W'(inter_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= pair.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid && adv_s1) begin
			dxa_s1 <= DIFF_W'(crd[2]) - DIFF_W'(crd[0]);
			dya_s1 <= DIFF_W'(crd[3]) - DIFF_W'(crd[1]);
			dxb_s1 <= DIFF_W'(crd[6]) - DIFF_W'(crd[4]);
			dyb_s1 <= DIFF_W'(crd[7]) - DIFF_W'(crd[5]);
			lft_s1 <= (crd[0] > crd[4]) ? crd[0] : crd[4];
			rgt_s1 <= (crd[2] < crd[6]) ? crd[2] : crd[6];
			bot_s1 <= (crd[1] > crd[5]) ? crd[1] : crd[5];
			hiy_s1 <= (crd[3] < crd[7]) ? crd[3] : crd[7];
		end
		if (vld_s1 && adv_s2) begin
			area_a_s2 <= dxa_s1 * dya_s1;
			area_b_s2 <= dxb_s1 * dyb_s1;
			iw_s2     <= DIFF_W'(rgt_s1) - DIFF_W'(lft_s1);
			ih_s2     <= DIFF_W'(hiy_s1) - DIFF_W'(bot_s1);
			ovl_s2    <= (rgt_s1 > lft_s1) && (hiy_s1 > bot_s1);
		end
		if (vld_s2 && adv_s3) begin
			area_a_s3 <= area_a_s2;
			area_b_s3 <= area_b_s2;
			inter_s3  <= iw_s2 * ih_s2;
			ovl_s3    <= ovl_s2;
		end
		if (vld_s3 && adv_s4) begin
			num_s4           <= inter_s3[DEN_W-1:0];
			den_s4           <= uni_c[DEN_W-1:0];
			flg_s4.overlap   <= ovl_s3;
			flg_s4.bad_union <= ovl_s3 && (uni_c[UNI_W-1] || uni_c == '0);
		end
	end

	assign out_valid = vld_s4;
	assign num       = num_s4;
	assign den       = den_s4;
	assign flg       = flg_s4;

endmodule

@@ src/biou_div_cell.sv @@
// One restoring-division cell: a compare/subtract yielding one quotient bit.
module biou_div_cell #(
	parameter int DEN_W = 34,
	parameter int Q_W   = 17,
	parameter bit SHIFT = 1'b1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DEN_W-1:0]      rem_in,
	input  logic [DEN_W-1:0]      den_in,
	input  logic [Q_W-1:0]        q_in,
	input  biou_pkg::biou_flags_t flg_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DEN_W-1:0]      rem_out,
	output logic [DEN_W-1:0]      den_out,
	output logic [Q_W-1:0]        q_out,
	output biou_pkg::biou_flags_t flg_out
);
	import biou_pkg::*;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             take;
	logic [Q_W-1:0]   q_sh;

	logic             vld_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [Q_W-1:0]   q_q;
	biou_flags_t      flg_q;

	always_comb begin
		rem_sh = SHIFT ? {rem_in, 1'b0} : {1'b0, rem_in};
		diff   = rem_sh - {1'b0, den_in};
		take   = rem_sh >= {1'b0, den_in};
		q_sh   = SHIFT ? {q_in[Q_W-2:0], take} : {{(Q_W-1){1'b0}}, take};
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			den_q <= den_in;
			q_q   <= q_sh;
			flg_q <= flg_in;
		end
	end

	assign out_valid = vld_q;
	assign rem_out   = rem_q;
	assign den_out   = den_q;
	assign q_out     = q_q;
	assign flg_out   = flg_q;

endmodule

@@ src/biou_round.sv @@
// Output stage: round to nearest, saturate, force empty cases to zero.
module biou_round #(
	parameter int DEN_W = 34,
	parameter int Q_W   = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DEN_W-1:0]      rem_in,
	input  logic [DEN_W-1:0]      den_in,
	input  logic [Q_W-1:0]        q_in,
	input  biou_pkg::biou_flags_t flg_in,
	biou_result_if.source         result
);
	import biou_pkg::*;

	logic           rnd;
	logic [Q_W-1:0] qr;
	ratio_t         sat;
	ratio_t         ratio_c;

	logic           vld_q;
	ratio_t         ratio_q;
	logic           ovl_q, bad_q;

	assign rnd = {rem_in, 1'b0} >= {1'b0, den_in};
	assign qr  = q_in + Q_W'(rnd);

	if (Q_W > RATIO_BITS) begin : g_sat
		assign sat = (|qr[Q_W-1:RATIO_BITS]) ? {RATIO_BITS{1'b1}} : qr[RATIO_BITS-1:0];
	end else begin : g_pad
		assign sat = RATIO_BITS'(qr);
	end

	assign ratio_c  = (flg_in.overlap && !flg_in.bad_union) ? sat : '0;
	assign in_ready = !vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ratio_q <= ratio_c;
			ovl_q   <= flg_in.overlap;
			bad_q   <= flg_in.bad_union;
		end
	end

	assign result.valid         = vld_q;
	assign result.overlap_ratio = ratio_q;
	assign result.boxes_overlap = ovl_q;
	assign result.bad_union     = bad_q;

endmodule

@@ src/box_iou_ratio_top.sv @@
// Top level of the box IoU ratio block: front pipeline, divider cell row, output stage.
//
//   channel   dir   payload                                          accept
//   pair      in    box_a_* / box_b_* corners, 8 x 16 bit signed     valid & ready
//   result    out   overlap_ratio[16:0], boxes_overlap, bad_union     valid & ready
//
// One box pair per cycle while result is not stalled; 4 front stages,
// FRACTION_BITS + 1 divider cells, one output stage.
// Each divider cell resolves one quotient bit with one wide compare/subtract.
// arst_n clears only the valid flags; the pipeline is empty after reset.
// A stall at result holds in the same cycle every full stage with only full stages after it; empty stages keep filling.
`include "box_iou_ratio_top_macros.svh"

module box_iou_ratio_top #(
	parameter int COORD_BITS    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	biou_pair_if.sink     pair,
	biou_result_if.source result
);
	import biou_pkg::*;

	localparam int DEN_W     = 2 * COORD_BITS + 2;
	localparam int Q_W       = FRACTION_BITS + 1;
	localparam int NCELL     = FRACTION_BITS + 1;
	localparam int RATIO_TOP = (FRACTION_BITS >= RATIO_BITS) ?
		((1 << RATIO_BITS) - 1) : (1 << FRACTION_BITS);

	logic             lnk_vld [NCELL+1];
	logic             lnk_rdy [NCELL+1];
	logic [DEN_W-1:0] lnk_rem [NCELL+1];
	logic [DEN_W-1:0] lnk_den [NCELL+1];
	logic [Q_W-1:0]   lnk_q   [NCELL+1];
	biou_flags_t      lnk_flg [NCELL+1];

	biou_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.out_valid (lnk_vld[0]),
		.out_ready (lnk_rdy[0]),
		.num       (lnk_rem[0]),
		.den       (lnk_den[0]),
		.flg       (lnk_flg[0])
	);

	assign lnk_q[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		biou_div_cell #(
			.DEN_W (DEN_W),
			.Q_W   (Q_W),
			.SHIFT (i != 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (lnk_vld[i]),
			.in_ready  (lnk_rdy[i]),
			.rem_in    (lnk_rem[i]),
			.den_in    (lnk_den[i]),
			.q_in      (lnk_q[i]),
			.flg_in    (lnk_flg[i]),
			.out_valid (lnk_vld[i+1]),
			.out_ready (lnk_rdy[i+1]),
			.rem_out   (lnk_rem[i+1]),
			.den_out   (lnk_den[i+1]),
			.q_out     (lnk_q[i+1]),
			.flg_out   (lnk_flg[i+1])
		);
	end

	biou_round #(
		.DEN_W (DEN_W),
		.Q_W   (Q_W)
	) u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (lnk_vld[NCELL]),
		.in_ready (lnk_rdy[NCELL]),
		.rem_in   (lnk_rem[NCELL]),
		.den_in   (lnk_den[NCELL]),
		.q_in     (lnk_q[NCELL]),
		.flg_in   (lnk_flg[NCELL]),
		.result   (result)
	);

	`BIOU_IMPLY(a_empty_is_zero, clk, arst_n, result.valid && !result.boxes_overlap, result.overlap_ratio == '0 && !result.bad_union, "empty overlap gave nonzero result")
	`BIOU_IMPLY(a_bad_is_zero, clk, arst_n, result.valid && result.bad_union, result.boxes_overlap && result.overlap_ratio == '0, "bad union without zero ratio")
	`BIOU_IMPLY(a_ratio_range, clk, arst_n, result.valid, result.overlap_ratio <= RATIO_BITS'(RATIO_TOP), "ratio above one")
	`BIOU_IMPLY_NEXT(a_last_cell_holds, clk, arst_n, lnk_vld[NCELL] && !lnk_rdy[NCELL], lnk_vld[NCELL], "divider beat lost under stall")

endmodule
